FILE: rtl/qvr_pkg.sv
// Package: item and result types and fixed widths for the quaternion vector rotator.
package qvr_pkg;

    // Divider: quotient bits, one per pipeline step
    localparam int QBITS    = 31;
    localparam int DEN_W    = 33;
    localparam int DVD_W    = 63;
    localparam int FRAC     = 30;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic               inverse;
    } req_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               zero_quat;
        logic               saturated;
    } rsp_t;

endpackage

FILE: rtl/qvr_div.sv
// Pipelined restoring divider, one quotient bit per stage, for the matrix entry scaling.
module qvr_div (
    input  logic                         clk,
    input  logic [qvr_pkg::DVD_W-1:0]    dividend,
    input  logic [qvr_pkg::DEN_W-1:0]    den,
    output logic [qvr_pkg::QBITS-1:0]    quot
);
    import qvr_pkg::*;

    // stage s holds partial remainder, remaining dividend bits / quotient bits, divisor
    logic [DEN_W-1:0] rem_reg  [0:QBITS];
    logic [QBITS-1:0] word_reg [0:QBITS];
    logic [DEN_W-1:0] den_reg  [0:QBITS];
    logic [DEN_W-1:0] rem_next [0:QBITS-1];
    logic [QBITS-1:0] word_next[0:QBITS-1];
    logic [DEN_W:0]   trial    [0:QBITS-1];
    logic             ge       [0:QBITS-1];

    // One compare and subtract per stage
    always_comb
    begin
        for (int s = 0; s < QBITS; s++)
        begin
            trial[s]     = {rem_reg[s], word_reg[s][QBITS-1]};
            ge[s]        = trial[s] >= {1'b0, den_reg[s]};
            rem_next[s]  = ge[s] ? DEN_W'(trial[s] - {1'b0, den_reg[s]})
                                 : trial[s][DEN_W-1:0];
            word_next[s] = {word_reg[s][QBITS-2:0], ge[s]};
        end
    end

    // Stage registers
    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= {1'b0, dividend[DVD_W-1:QBITS]};
        word_reg[0] <= dividend[QBITS-1:0];
        den_reg[0]  <= den;
        for (int s = 0; s < QBITS; s++)
        begin
            rem_reg[s+1]  <= rem_next[s];
            word_reg[s+1] <= word_next[s];
            den_reg[s+1]  <= den_reg[s];
        end
    end

    assign quot = word_reg[QBITS];

endmodule

FILE: rtl/quaternion_vector_rotate.sv
// Top level: fully pipelined quaternion vector rotation.
// One item is taken in every cycle (busy is always low) and its result comes out
// on result, marked by a one-cycle done strobe.
// The latency is set by the 32-stage restoring divider (an input register and 31
// quotient-bit steps) that scales the rotation matrix by the squared magnitude; the
// rest is input, product, numerator, dividend, entry, product, sum and output stages.
// The receiver cannot stall the block.
module quaternion_vector_rotate (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  qvr_pkg::req_t  req,
    output logic           done,
    output qvr_pkg::rsp_t  result
);
    import qvr_pkg::*;

    localparam int DIV_LAT = QBITS + 1;

    typedef struct packed {
        logic                  zero;
        logic [8:0]            sign;
        logic [2:0][31:0]      vec;
    } side_t;

    function automatic logic [DEN_W-1:0] mag33(input logic signed [35:0] a);
        logic signed [35:0] n;
        n = -a;
        return a[35] ? n[DEN_W-1:0] : a[DEN_W-1:0];
    endfunction

    // valid line: s1 s2 s3 s4, divider, entry, product, sum, out
    localparam int NV = 4 + DIV_LAT + 4;
    logic [NV-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[NV-2:0], start};
    end

    assign busy = 1'b0;
    assign done = vld_reg[NV-1];

    // Stage 1: register, conjugate for inverse
    logic signed [16:0] w1_reg, x1_reg, y1_reg, z1_reg;
    logic [2:0][31:0]   v1_reg;
    always_ff @(posedge clk)
    begin
        w1_reg <= 17'(req.quat_w);
        x1_reg <= req.inverse ? -17'(req.quat_x) : 17'(req.quat_x);
        y1_reg <= req.inverse ? -17'(req.quat_y) : 17'(req.quat_y);
        z1_reg <= req.inverse ? -17'(req.quat_z) : 17'(req.quat_z);
        v1_reg <= {req.vec_z, req.vec_y, req.vec_x};
    end

    // Stage 2: products of quaternion parts
    logic signed [33:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [33:0] xy_reg, wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;
    logic [2:0][31:0]   v2_reg;
    always_ff @(posedge clk)
    begin
        ww_reg <= w1_reg * w1_reg;
        xx_reg <= x1_reg * x1_reg;
        yy_reg <= y1_reg * y1_reg;
        zz_reg <= z1_reg * z1_reg;
        xy_reg <= x1_reg * y1_reg;
        wz_reg <= w1_reg * z1_reg;
        xz_reg <= x1_reg * z1_reg;
        wy_reg <= w1_reg * y1_reg;
        yz_reg <= y1_reg * z1_reg;
        wx_reg <= w1_reg * x1_reg;
        v2_reg <= v1_reg;
    end

    // Stage 3: matrix numerators and squared norm
    logic signed [35:0] nm [0:8];
    logic [DEN_W-1:0]   n2_next;
    always_comb
    begin
        nm[0] = 36'(ww_reg) + 36'(xx_reg) - 36'(yy_reg) - 36'(zz_reg);
        nm[1] = (36'(xy_reg) - 36'(wz_reg)) <<< 1;
        nm[2] = (36'(xz_reg) + 36'(wy_reg)) <<< 1;
        nm[3] = (36'(xy_reg) + 36'(wz_reg)) <<< 1;
        nm[4] = 36'(ww_reg) - 36'(xx_reg) + 36'(yy_reg) - 36'(zz_reg);
        nm[5] = (36'(yz_reg) - 36'(wx_reg)) <<< 1;
        nm[6] = (36'(xz_reg) - 36'(wy_reg)) <<< 1;
        nm[7] = (36'(yz_reg) + 36'(wx_reg)) <<< 1;
        nm[8] = 36'(ww_reg) - 36'(xx_reg) - 36'(yy_reg) + 36'(zz_reg);
        n2_next = ww_reg[DEN_W-1:0] + xx_reg[DEN_W-1:0]
                + yy_reg[DEN_W-1:0] + zz_reg[DEN_W-1:0];
    end

    logic [DEN_W-1:0] mag3_reg [0:8];
    logic [DEN_W-1:0] n23_reg;
    side_t            sd3_reg;
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
        begin
            mag3_reg[k]     <= mag33(nm[k]);
            sd3_reg.sign[k] <= nm[k][35];
        end
        n23_reg      <= n2_next;
        sd3_reg.zero <= (n2_next == '0);
        sd3_reg.vec  <= v2_reg;
    end

    // Stage 4: dividend with half-divisor rounding term
    logic [DVD_W-1:0] dvd4_reg [0:8];
    logic [DEN_W-1:0] n24_reg;
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
            dvd4_reg[k] <= {mag3_reg[k], FRAC'(0)} + DVD_W'(n23_reg[DEN_W-1:1]);
        n24_reg <= n23_reg;
    end

    // Sideband aligned with the divider
    side_t sd_reg [0:DIV_LAT];
    always_ff @(posedge clk)
    begin
        sd_reg[0] <= sd3_reg;
        for (int s = 0; s < DIV_LAT; s++)
            sd_reg[s+1] <= sd_reg[s];
    end

    logic [QBITS-1:0] quot [0:8];
    for (genvar k = 0; k < 9; k++)
    begin : g_div
        qvr_div u_div (
            .clk      (clk),
            .dividend (dvd4_reg[k]),
            .den      (n24_reg),
            .quot     (quot[k])
        );
    end

    // Entry stage: signed Q2.30 matrix entries
    logic signed [31:0] m_reg [0:8];
    logic [2:0][31:0]   ve_reg;
    logic               ze_reg;
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
            m_reg[k] <= sd_reg[DIV_LAT].sign[k] ? -{1'b0, quot[k]} : {1'b0, quot[k]};
        ve_reg <= sd_reg[DIV_LAT].vec;
        ze_reg <= sd_reg[DIV_LAT].zero;
    end

    // Product stage: matrix times vector
    logic signed [63:0] p_reg [0:8];
    logic               zp_reg;
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                p_reg[r*3+c] <= m_reg[r*3+c] * $signed(ve_reg[c]);
        zp_reg <= ze_reg;
    end

    // Sum stage
    logic signed [63:0] s_reg [0:2];
    logic               zs_reg;
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
            s_reg[r] <= p_reg[r*3] + p_reg[r*3+1] + p_reg[r*3+2];
        zs_reg <= zp_reg;
    end

    // Output stage: round half away from zero, saturate
    logic [63:0]        amag [0:2];
    logic [33:0]        rnd  [0:2];
    logic signed [31:0] o    [0:2];
    logic [2:0]         clip;
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            amag[r] = s_reg[r][63] ? 64'(-s_reg[r]) : 64'(s_reg[r]);
            rnd[r]  = 34'((amag[r] + (64'd1 << (FRAC - 1))) >> FRAC);
            if (s_reg[r][63])
            begin
                clip[r] = rnd[r] > 34'h0_8000_0000;
                o[r]    = clip[r] ? 32'sh8000_0000 : 32'(-rnd[r]);
            end
            else
            begin
                clip[r] = rnd[r] > 34'h0_7FFF_FFFF;
                o[r]    = clip[r] ? 32'sh7FFF_FFFF : 32'(rnd[r]);
            end
        end
    end

    rsp_t rsp_reg;
    always_ff @(posedge clk)
    begin
        rsp_reg.out_x     <= zs_reg ? '0 : o[0];
        rsp_reg.out_y     <= zs_reg ? '0 : o[1];
        rsp_reg.out_z     <= zs_reg ? '0 : o[2];
        rsp_reg.zero_quat <= zs_reg;
        rsp_reg.saturated <= !zs_reg && (|clip);
    end

    assign result = rsp_reg;

endmodule

FILE: sim/quaternion_vector_rotate_tb.sv
// Testbench: quaternion vector rotation checked against an in-bench fixed-point predictor.
module quaternion_vector_rotate_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import qvr_pkg::*;

    localparam int N_RANDOM   = 700;
    localparam int IDLE_LIMIT = 2000;
    localparam int LATENCY    = 40;
    localparam int N_DIRECTED = 16;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    req_t req = '0;
    logic done;
    rsp_t result;

    int   mismatches = 0;
    int   idle_cycles = 0;
    rsp_t rotated_q[$];

    quaternion_vector_rotate DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req(req), .done(done), .result(result)
    );

    always #2 clk = ~clk;

    // Predictor: normalized rotation matrix, rounded entries, saturated outputs
    function automatic longint scaled_entry(longint num, longint n2);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = ((mag <<< 30) + n2 / 2) / n2;
        return (num < 0) ? -q : q;
    endfunction

    function automatic rsp_t rotate_vector(req_t r);
        longint w, x, y, z, ww, xx, yy, zz, n2, acc, mag, rnd;
        longint num[3][3];
        longint v[3];
        rsp_t o;
        o = '0;
        w = r.quat_w; x = r.quat_x; y = r.quat_y; z = r.quat_z;
        v[0] = r.vec_x; v[1] = r.vec_y; v[2] = r.vec_z;
        if (r.inverse)
        begin
            x = -x; y = -y; z = -z;
        end
        ww = w * w; xx = x * x; yy = y * y; zz = z * z;
        n2 = ww + xx + yy + zz;
        if (n2 == 0)
        begin
            o.zero_quat = 1'b1;
            return o;
        end
        num[0][0] = ww + xx - yy - zz;
        num[0][1] = 2 * (x * y - w * z);
        num[0][2] = 2 * (x * z + w * y);
        num[1][0] = 2 * (x * y + w * z);
        num[1][1] = ww - xx + yy - zz;
        num[1][2] = 2 * (y * z - w * x);
        num[2][0] = 2 * (x * z - w * y);
        num[2][1] = 2 * (y * z + w * x);
        num[2][2] = ww - xx - yy + zz;
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += scaled_entry(num[i][j], n2) * v[j];
            mag = (acc < 0) ? -acc : acc;
            rnd = (mag + (64'sd1 <<< 29)) >>> 30;
            if (acc < 0 && rnd > 64'sh80000000)
            begin
                rnd = 64'sh80000000; o.saturated = 1'b1;
            end
            if (acc >= 0 && rnd > 64'sh7FFFFFFF)
            begin
                rnd = 64'sh7FFFFFFF; o.saturated = 1'b1;
            end
            rnd = (acc < 0) ? -rnd : rnd;
            case (i)
                0: o.out_x = rnd[31:0];
                1: o.out_y = rnd[31:0];
                default: o.out_z = rnd[31:0];
            endcase
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    // Result checker and watchdog, sampled at the rising edge
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles > IDLE_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
                $display("quaternion_vector_rotate_tb: FAIL");
                $finish;
            end
            if (start && !busy)
                rotated_q.push_back(rotate_vector(req));
            if (done)
            begin
                if (rotated_q.size() == 0)
                begin
                    report_mismatch("result transfers pending", 1, 0);
                end
                else
                begin
                    want = rotated_q.pop_front();
                    if (result.out_x !== want.out_x)
                        report_mismatch("out_x", result.out_x, want.out_x);
                    if (result.out_y !== want.out_y)
                        report_mismatch("out_y", result.out_y, want.out_y);
                    if (result.out_z !== want.out_z)
                        report_mismatch("out_z", result.out_z, want.out_z);
                    if (result.zero_quat !== want.zero_quat)
                        report_mismatch("zero_quat", result.zero_quat, want.zero_quat);
                    if (result.saturated !== want.saturated)
                        report_mismatch("saturated", result.saturated, want.saturated);
                end
            end
        end
    end

    // Drive one transfer, holding start until accepted
    task automatic send_rotation(req_t r);
        req   <= r;
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_gap();
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
    endtask

    function automatic logic signed [15:0] rand_part();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh4000;
            3: return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'sh80000000;
            1: return 32'sh7FFFFFFF;
            2: return $signed($urandom_range(0, 'h3FFFF)) - 'sh20000;
            default: return $urandom;
        endcase
    endfunction

    // Directed rows: w, x, y, z, vx, vy, vz, inverse, and typed-in result where obvious
    req_t directed_req[N_DIRECTED];
    rsp_t directed_rsp[N_DIRECTED];
    bit   directed_known[N_DIRECTED];

    initial
    begin
        req_t r;
        int burst;
        int sent;
        // identity and zero quaternion rows have results readable at a glance
        directed_req[0]  = '{16'sh4000, 0, 0, 0, 32'sh00010000, 32'sh00020000, -32'sh30000, 1'b0};
        directed_rsp[0]  = '{32'sh00010000, 32'sh00020000, -32'sh30000, 1'b0, 1'b0};
        directed_known[0] = 1;
        directed_req[1]  = '{0, 0, 0, 0, 32'sh7FFFFFFF, 32'sh80000000, 5, 1'b0};
        directed_rsp[1]  = '{0, 0, 0, 1'b1, 1'b0};
        directed_known[1] = 1;
        directed_req[2]  = '{0, 0, 0, 0, 1, 2, 3, 1'b1};
        directed_rsp[2]  = '{0, 0, 0, 1'b1, 1'b0};
        directed_known[2] = 1;
        directed_req[3]  = '{16'sh8000, 0, 0, 0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1'b1};
        directed_rsp[3]  = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1'b0, 1'b0};
        directed_known[3] = 1;
        directed_req[4]  = '{16'sh2D41, 0, 0, 16'sh2D41, 32'sh00010000, 0, 0, 1'b0};
        directed_req[5]  = '{16'sh2D41, 0, 0, 16'sh2D41, 32'sh00010000, 0, 0, 1'b1};
        directed_req[6]  = '{0, 16'sh8000, 16'sh8000, 16'sh8000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                             32'sh7FFFFFFF, 1'b1};
        directed_req[7]  = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'sh7FFFFFFF,
                             32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0};
        directed_req[8]  = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 32'sh80000000,
                             32'sh80000000, 32'sh80000000, 1'b1};
        directed_req[9]  = '{16'sh2000, 16'sh2000, 16'sh2000, 16'sh2000, 32'sh7FFFFFFF,
                             32'sh7FFFFFFF, 0, 1'b0};
        directed_req[10] = '{0, 16'sh0001, 0, 0, 32'sh12345678, -32'sh1234, 7, 1'b0};
        directed_req[11] = '{0, 0, 16'sh8000, 0, 32'sh00008000, 32'sh7FFFFFFF, -1, 1'b1};
        directed_req[12] = '{0, 0, 0, 16'sh0001, -1, 1, 32'sh80000000, 1'b0};
        directed_req[13] = '{16'sh0001, 16'sh0001, 16'sh0001, 16'sh0001, 32'sh00008000,
                             -32'sh8000, 32'sh00007FFF, 1'b0};
        directed_req[14] = '{16'sh7FFF, 16'sh8000, 0, 16'sh7FFF, 32'sh7FFFFFFF, 32'sh80000000,
                             32'sh7FFFFFFF, 1'b1};
        directed_req[15] = '{16'shFFFF, 16'sh0000, 16'sh7FFF, 16'sh8000, 32'shFFFFFFFF, 0,
                             32'sh80000000, 1'b0};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table; typed-in results cross-check the predictor
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (directed_known[i] && rotate_vector(directed_req[i]) !== directed_rsp[i])
                report_mismatch("directed row vs table", i, i);
            send_rotation(directed_req[i]);
            if ($urandom_range(0, 2) == 0)
                send_gap();
        end

        // Random part: bursts of back-to-back transfers with random gaps
        sent = 0;
        while (sent < N_RANDOM)
        begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < N_RANDOM; k++)
            begin
                r.quat_w  = rand_part();
                r.quat_x  = rand_part();
                r.quat_y  = rand_part();
                r.quat_z  = rand_part();
                r.vec_x   = rand_coord();
                r.vec_y   = rand_coord();
                r.vec_z   = rand_coord();
                r.inverse = 1'($urandom_range(0, 1));
                send_rotation(r);
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                send_gap();
        end
        start <= 1'b0;

        // Drain, then let the pipeline settle
        while (rotated_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0)
            $display("quaternion_vector_rotate_tb: PASS");
        else
            $display("quaternion_vector_rotate_tb: FAIL");
        $finish;
    end
endmodule
